/* rtl/comment_blanking_filter_macros.svh */
// assertion macros for the comment blanking filter
`ifndef COMMENT_BLANKING_FILTER_MACROS_SVH
`define COMMENT_BLANKING_FILTER_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define CBF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbf check failed");

// antecedent implies consequent in the same cycle
`define CBF_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbf check failed");

`endif

/* rtl/cbf_pkg.sv */
// shared types and character constants for the comment blanking filter
package cbf_pkg;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // result bytes produced by one accepted input beat
   typedef struct packed {
      logic [1:0] num;
      logic [7:0] char0;
      logic [7:0] char1;
   } cbf_push_type;

   // one queued result beat
   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } cbf_entry_type;

   // queue status seen by the front end
   typedef struct packed {
      logic room2;
      logic empty;
   } cbf_qstat_type;

endpackage

/* rtl/cbf_front.sv */
// front end: accepts text beats, runs the lexer and classifies result bytes
module cbf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_ch,
   input  logic                   req_first,
   input  cbf_pkg::cbf_qstat_type qstat,
   output cbf_pkg::cbf_push_type  push
);
   import cbf_pkg::*;

   typedef enum logic [2:0] {
      ST_START      = 3'd0,
      ST_SLASH      = 3'd1,
      ST_LINE       = 3'd2,
      ST_BLOCK      = 3'd3,
      ST_BLOCK_STAR = 3'd4,
      ST_QUOTE      = 3'd5,
      ST_ESCAPE     = 3'd6
   } lex_state_type;

   lex_state_type state_ff, state_in, cur_state;
   logic          cmt_ff, cmt_in, cur_cmt;
   logic          sw_emit, pass, pass_emit, fire;
   logic [7:0]    sw_char, pass_char;

   assign req_ready = qstat.room2;
   assign fire      = req_valid & req_ready;

   always_comb begin
      cur_state = req_first ? ST_START : state_ff;
      cur_cmt   = req_first ? 1'b0 : cmt_ff;
      state_in  = cur_state;
      cmt_in    = cur_cmt;
      sw_emit   = 1'b0;
      sw_char   = CH_SPACE;
      pass      = 1'b1;
      case (cur_state)
         ST_SLASH: begin
            if (req_ch == CH_SLASH) begin
               cmt_in   = 1'b1;
               sw_emit  = 1'b1;
               state_in = ST_LINE;
            end else if (req_ch == CH_STAR) begin
               cmt_in   = 1'b1;
               sw_emit  = 1'b1;
               state_in = ST_BLOCK;
            end else begin
               sw_emit  = 1'b1;
               sw_char  = CH_SLASH;
               state_in = ST_START;
            end
         end
         ST_LINE: begin
            if (req_ch == CH_CR || req_ch == CH_LF) begin
               cmt_in   = 1'b0;
               state_in = ST_START;
            end
         end
         ST_BLOCK: begin
            if (req_ch == CH_STAR) state_in = ST_BLOCK_STAR;
         end
         ST_BLOCK_STAR: begin
            if (req_ch == CH_SLASH) begin
               cmt_in   = 1'b0;
               sw_emit  = 1'b1;
               state_in = ST_START;
               pass     = 1'b0;
            end else if (req_ch != CH_STAR) begin
               state_in = ST_BLOCK;
            end
         end
         ST_QUOTE: begin
            if (req_ch == CH_QUOTE) state_in = ST_START;
            else if (req_ch == CH_BSL) state_in = ST_ESCAPE;
         end
         ST_ESCAPE: begin
            state_in = ST_QUOTE;
         end
         default: begin
            // normal text, also the unused code
            if (req_ch == CH_SLASH) begin
               state_in = ST_SLASH;
               pass     = 1'b0;
            end else if (req_ch == CH_HASH) begin
               cmt_in   = 1'b1;
               state_in = ST_LINE;
            end else if (req_ch == CH_QUOTE) begin
               state_in = ST_QUOTE;
            end else begin
               state_in = ST_START;
            end
         end
      endcase

      pass_emit = pass & (req_ch != CH_CR);
      if (cmt_in && !(req_ch inside {CH_CR, CH_LF, CH_SPACE, CH_TAB}))
         pass_char = CH_SPACE;
      else
         pass_char = req_ch;
   end

   always_comb begin
      push.num   = fire ? ({1'b0, sw_emit} + {1'b0, pass_emit}) : 2'd0;
      push.char0 = sw_emit ? sw_char : pass_char;
      push.char1 = pass_char;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         cmt_ff   <= 1'b0;
      end else if (fire) begin
         state_ff <= state_in;
         cmt_ff   <= cmt_in;
      end
   end

endmodule

/* rtl/cbf_queue.sv */
// back end: result queue taking up to two bytes a cycle, delivering one
module cbf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cbf_pkg::cbf_push_type         push,
   output cbf_pkg::cbf_qstat_type        qstat,
   output logic [$clog2(DEPTH+1)-1:0]    count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last
);
   import cbf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   cbf_entry_type    mem [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;

   assign pop          = rsp_valid & rsp_ready;
   assign rsp_valid    = (cnt_ff != '0);
   assign rsp_out_char = mem[rd_ff].out_char;
   assign rsp_last     = mem[rd_ff].last;
   assign count        = cnt_ff;
   assign qstat.room2  = (cnt_ff <= CNT_W'(DEPTH - 2));
   assign qstat.empty  = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff + PTR_W'(push.num);
      rd_in  = rd_ff + PTR_W'(pop);
      cnt_in = cnt_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem[wr_ff] <= '{out_char: push.char0, last: (push.num == 2'd1)};
      end
      if (push.num == 2'd2) begin
         mem[wr_ff + PTR_W'(1)] <= '{out_char: push.char1, last: 1'b1};
      end
   end

endmodule

/* rtl/comment_blanking_filter.sv */
// top level of the comment blanking filter
//
// req channel: one text byte per beat (req_ch) with req_first marking the
//   start of a new text; the lexer state is cleared before that byte
// rsp channel: zero, one or two bytes per input beat; rsp_last marks the
//   final byte caused by an input beat
// a held slash gives no byte until the next input decides what it was
// result bytes are written into the result queue on the accepted beat and offered in order
// throughput: one input beat per cycle while req_ready is high; the output
//   side moves one byte per cycle while rsp_ready is high, so the second byte
//   of an item with two results waits in the result queue
// req_ready drops while the queue has room for fewer than two bytes
// a stalled receiver fills the queue, then stalls the sender; nothing is
//   lost or repeated
// reset: synchronous, clears lexer state and empties the queue
// a slash pending at end of text is dropped by the next req_first
module comment_blanking_filter #(
   parameter int DEPTH = 4   // result queue entries, power of two, >= 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_first,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last
);
   import cbf_pkg::*;

   `include "comment_blanking_filter_macros.svh"

   localparam int CNT_W = $clog2(DEPTH+1);

   cbf_push_type     push;
   cbf_qstat_type    qstat;
   logic [CNT_W-1:0] q_count;

   // front end: lexer and classification
   cbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .req_first (req_first),
      .qstat     (qstat),
      .push      (push)
   );

   // back end: result queue driving the rsp channel
   cbf_queue #(.DEPTH(DEPTH)) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .qstat        (qstat),
      .count        (q_count),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   // queue never holds more than its depth
   `CBF_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, q_count <= CNT_W'(DEPTH))
   // fill level follows pushes and pops exactly
   `CBF_ASSERT_NEXT(a_count_track, clock, reset, 1'b1, q_count == $past(q_count) + CNT_W'($past(push.num)) - CNT_W'($past(rsp_valid & rsp_ready)))
   // pushes only happen on accepted beats
   `CBF_ASSERT_SAME(a_push_on_accept, clock, reset, push.num != 2'd0, req_valid && req_ready)
   // empty queue with no push stays silent
   `CBF_ASSERT_NEXT(a_no_invent, clock, reset, qstat.empty && push.num == 2'd0, !rsp_valid)

endmodule
